// File: rtl/core/bcc_pkg.sv
// Shared types, constants and saturation helpers for the battery coulomb counter.
// Depends on nothing; every other file of the block but bcc_checker imports it.
package bcc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned DIV_W      = 42;  // widest divisor magnitude (full capacity)

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 3'd5;

  // Item operation codes.
  localparam logic [1:0] OP_CURRENT = 2'd0;
  localparam logic [1:0] OP_MOTOR   = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [9:0]  MILLI_DIV   = 10'd1000;

  // Register values after reset.
  localparam logic [7:0]  RST_CELL_COUNT = 8'd40;
  localparam logic [15:0] RST_MIN_CELL   = 16'd3200;
  localparam logic [15:0] RST_MAX_CELL   = 16'd4200;
  localparam logic [15:0] RST_START_CELL = 16'd4200;
  localparam logic [19:0] RST_CAPACITY   = 20'd40000;
  localparam logic [15:0] RST_RESISTANCE = 16'd300;

  // Charge and pack voltage that the reset configuration yields: a full pack at no load.
  localparam logic signed [47:0] RST_CHARGE = 48'sd144000000000;
  localparam logic signed [23:0] RST_PACK   = 24'sd168000;

  typedef struct packed {
    logic [7:0]  cell_count;
    logic [15:0] min_cell_mv;
    logic [15:0] max_cell_mv;
    logic [15:0] start_cell_mv;
    logic [19:0] capacity_mah;
    logic [15:0] inner_resistance_mohm;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               div;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } md_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
    if (v > 64'sd1048575) begin
      return 21'sh0FFFFF;
    end else if (v < -64'sd1048576) begin
      return 21'sh100000;
    end
    return v[20:0];
  endfunction

endpackage

// File: rtl/core/bcc_cfg.sv
// Configuration register file of the battery coulomb counter.
// Depends on bcc_pkg for the register indexes, reset values and cfg_t.
module bcc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] wr_data_i,
  output bcc_pkg::cfg_t                  cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_CELL_COUNT: cfg_d.cell_count            = wr_data_i[7:0];
        REG_MIN_CELL:   cfg_d.min_cell_mv           = wr_data_i[15:0];
        REG_MAX_CELL:   cfg_d.max_cell_mv           = wr_data_i[15:0];
        REG_START_CELL: cfg_d.start_cell_mv         = wr_data_i[15:0];
        REG_CAPACITY:   cfg_d.capacity_mah          = wr_data_i[19:0];
        REG_RESISTANCE: cfg_d.inner_resistance_mohm = wr_data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_count            <= RST_CELL_COUNT;
      cfg_q.min_cell_mv           <= RST_MIN_CELL;
      cfg_q.max_cell_mv           <= RST_MAX_CELL;
      cfg_q.start_cell_mv         <= RST_START_CELL;
      cfg_q.capacity_mah          <= RST_CAPACITY;
      cfg_q.inner_resistance_mohm <= RST_RESISTANCE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/bcc_muldiv.sv
// Bit-serial signed multiplier and divider shared by every step of the counter.
// Depends on bcc_pkg for md_req_t and the divisor width.
module bcc_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcc_pkg::md_req_t   req_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);
  import bcc_pkg::*;

  // The second multiplier operand never exceeds 32 magnitude bits; dividends need all 64.
  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd63;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             div_q, div_d;
  logic             neg_q, neg_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      opa_q, opa_d;
  logic [DIV_W-1:0] opb_q, opb_d;
  logic [DIV_W-1:0] rem_q, rem_d;

  logic [63:0]      a_mag, b_mag;
  logic [DIV_W:0]   shifted, trial;
  logic             fits;

  assign a_mag   = req_i.a[63] ? (~req_i.a + 64'd1) : req_i.a;
  assign b_mag   = req_i.b[63] ? (~req_i.b + 64'd1) : req_i.b;
  assign shifted = {rem_q, acc_q[63]};
  assign trial   = shifted - {1'b0, opb_q};
  assign fits    = (shifted >= {1'b0, opb_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.div;
      neg_d  = req_i.a[63] ^ req_i.b[63];
      cnt_d  = req_i.div ? DIV_LAST : MUL_LAST;
      acc_d  = req_i.div ? a_mag : 64'd0;
      opa_d  = a_mag;
      opb_d  = req_i.div ? b_mag[DIV_W-1:0] : {{(DIV_W-32){1'b0}}, b_mag[31:0]};
      rem_d  = '0;
    end else if (busy_q) begin
      if (div_q) begin
        // Restoring division: one quotient bit enters at the bottom of acc each cycle.
        rem_d = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        acc_d = {acc_q[62:0], fits};
      end else begin
        if (opb_q[0]) begin
          acc_d = acc_q + opa_q;
        end
        opa_d = {opa_q[62:0], 1'b0};
        opb_d = {1'b0, opb_q[DIV_W-1:1]};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? $signed(~acc_q + 64'd1) : $signed(acc_q);

endmodule

// File: rtl/core/battery_coulomb_counter.sv
// Top level of the battery coulomb counter: item sequencer, pack state and result register.
// Depends on bcc_pkg, bcc_cfg and bcc_muldiv.
//
//   channel   direction   handshake                  payload
//   in        sink        in_valid_i / in_stall_o    op, current, force, speed, elapsed
//   out       source      out_valid_o / out_stall_i  pack, cell, above_minimum, current, status
//   cfg       sink        cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time. Every multiply and divide of an item runs in the shared bit-serial unit;
// a motor item that is skipped, a zero capacity or an empty span leaves steps out. A result
// still stalled in the output register holds the next one back for as long as the stall
// lasts. The next item is taken while a result waits.
// Reset is asynchronous and loads the charge and pack voltage of a full pack at no load.
module battery_coulomb_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic signed [20:0]             current_ma_i,
  input  logic signed [31:0]             force_mn_i,
  input  logic signed [31:0]             speed_milli_i,
  input  logic [15:0]                    elapsed_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [23:0]             pack_mv_o,
  output logic signed [23:0]             cell_mv_o,
  output logic                           above_minimum_o,
  output logic signed [20:0]             applied_current_ma_o,
  output logic                           status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bcc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MMUL  = 4'd1;   // force times speed
  localparam logic [3:0] S_MDIV  = 4'd2;   // power over pack voltage
  localparam logic [3:0] S_TMUL  = 4'd3;   // current times elapsed time
  localparam logic [3:0] S_RTOT  = 4'd4;   // full capacity for restart
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_RDIV  = 4'd6;
  localparam logic [3:0] S_CELL  = 4'd7;   // start of the cell voltage sequence
  localparam logic [3:0] S_CTOT  = 4'd8;
  localparam logic [3:0] S_CMUL  = 4'd9;
  localparam logic [3:0] S_CDIV  = 4'd10;
  localparam logic [3:0] S_PMUL  = 4'd11;  // resistance times current
  localparam logic [3:0] S_PDIV  = 4'd12;
  localparam logic [3:0] S_PCMUL = 4'd13;  // cells times cell voltage
  localparam logic [3:0] S_OUT   = 4'd14;

  cfg_t               cfg;
  md_req_t            md_req;
  logic               md_done;
  logic signed [63:0] md_res;

  logic [3:0]         state_q, state_d;
  logic               issue_q, issue_d;
  logic               out_valid_q, out_valid_d;

  logic signed [47:0] charge_q, charge_d;
  logic signed [20:0] pending_q, pending_d;
  logic signed [20:0] last_q, last_d;
  logic signed [23:0] pack_q, pack_d;

  logic [1:0]         op_q, op_d;
  logic signed [31:0] force_q, force_d;
  logic signed [31:0] speed_q, speed_d;
  logic [15:0]        elapsed_q, elapsed_d;
  logic               status_q, status_d;
  logic [DIV_W-1:0]   tot_q, tot_d;
  logic signed [63:0] tmp_q, tmp_d;
  logic signed [27:0] drop_q, drop_d;
  logic signed [23:0] cell_q, cell_d;

  logic signed [23:0] pack_out_q, pack_out_d;
  logic signed [23:0] cell_out_q, cell_out_d;
  logic               above_out_q, above_out_d;
  logic signed [20:0] applied_out_q, applied_out_d;
  logic               status_out_q, status_out_d;

  logic signed [16:0] min_s, span, diff;
  logic               in_fire;
  logic [3:0]         after_cell;

  bcc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .done_o (md_done),
    .res_o  (md_res)
  );

  assign min_s      = $signed({1'b0, cfg.min_cell_mv});
  assign span       = $signed({1'b0, cfg.max_cell_mv}) - min_s;
  assign diff       = $signed({1'b0, cfg.start_cell_mv}) - min_s;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  // Tick and restart also refresh the pack voltage once the cell voltage is known.
  assign after_cell = (op_q == OP_TICK || op_q == OP_RESTART) ? S_PMUL : S_OUT;

  // Operands for the shared unit, chosen by the step in progress.
  always_comb begin
    md_req.start = issue_q;
    md_req.div   = 1'b0;
    md_req.a     = '0;
    md_req.b     = '0;
    case (state_q)
      S_MMUL: begin
        md_req.a = 64'(force_q);
        md_req.b = 64'(speed_q);
      end
      S_MDIV: begin
        md_req.div = 1'b1;
        md_req.a   = tmp_q;
        md_req.b   = 64'(pack_q);
      end
      S_TMUL: begin
        md_req.a = 64'(pending_q);
        md_req.b = 64'(elapsed_q);
      end
      S_RTOT, S_CTOT: begin
        md_req.a = 64'(MS_PER_HOUR);
        md_req.b = 64'(cfg.capacity_mah);
      end
      S_RMUL: begin
        md_req.a = 64'(tot_q);
        md_req.b = 64'(diff);
      end
      S_RDIV: begin
        md_req.div = 1'b1;
        md_req.a   = tmp_q;
        md_req.b   = 64'(span);
      end
      S_CMUL: begin
        md_req.a = 64'(charge_q);
        md_req.b = 64'(span);
      end
      S_CDIV: begin
        md_req.div = 1'b1;
        md_req.a   = tmp_q;
        md_req.b   = 64'(tot_q);
      end
      S_PMUL: begin
        md_req.a = 64'(pending_q);
        md_req.b = 64'(cfg.inner_resistance_mohm);
      end
      S_PDIV: begin
        md_req.div = 1'b1;
        md_req.a   = tmp_q;
        md_req.b   = 64'(MILLI_DIV);
      end
      S_PCMUL: begin
        md_req.a = 64'(cell_q);
        md_req.b = 64'(cfg.cell_count);
      end
      default: begin
        md_req.div = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    charge_d      = charge_q;
    pending_d     = pending_q;
    last_d        = last_q;
    pack_d        = pack_q;
    op_d          = op_q;
    force_d       = force_q;
    speed_d       = speed_q;
    elapsed_d     = elapsed_q;
    status_d      = status_q;
    tot_d         = tot_q;
    tmp_d         = tmp_q;
    drop_d        = drop_q;
    cell_d        = cell_q;
    pack_out_d    = pack_out_q;
    cell_out_d    = cell_out_q;
    above_out_d   = above_out_q;
    applied_out_d = applied_out_q;
    status_out_d  = status_out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d      = op_i;
          force_d   = force_mn_i;
          speed_d   = speed_milli_i;
          elapsed_d = elapsed_ms_i;
          status_d  = 1'b0;
          case (op_i)
            OP_CURRENT: begin
              pending_d = sat21(64'(pending_q) + 64'(current_ma_i));
              state_d   = S_CELL;
            end
            OP_MOTOR: begin
              if (pack_q <= 24'sd0) begin
                status_d = 1'b1;
                state_d  = S_CELL;
              end else begin
                state_d = S_MMUL;
              end
            end
            OP_TICK: begin
              state_d = S_TMUL;
            end
            OP_RESTART: begin
              if (span == 17'sd0) begin
                charge_d = '0;
                state_d  = S_CELL;
              end else begin
                state_d = S_RTOT;
              end
            end
            default: begin
              state_d = S_CELL;
            end
          endcase
        end
      end
      S_MMUL: begin
        if (md_done) begin
          tmp_d   = md_res;
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        if (md_done) begin
          pending_d = sat21(64'(pending_q) + 64'(sat24(md_res)));
          state_d   = S_CELL;
        end
      end
      S_TMUL: begin
        if (md_done) begin
          charge_d = sat48(64'(charge_q) - md_res);
          state_d  = S_CELL;
        end
      end
      S_RTOT: begin
        if (md_done) begin
          tot_d   = md_res[DIV_W-1:0];
          state_d = S_RMUL;
        end
      end
      S_RMUL: begin
        if (md_done) begin
          tmp_d   = md_res;
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (md_done) begin
          charge_d = sat48(md_res);
          state_d  = S_CELL;
        end
      end
      S_CELL: begin
        // With no capacity the cell sits at its minimum voltage.
        if (cfg.capacity_mah == '0) begin
          cell_d  = 24'(min_s);
          state_d = after_cell;
        end else begin
          state_d = S_CTOT;
        end
      end
      S_CTOT: begin
        if (md_done) begin
          tot_d   = md_res[DIV_W-1:0];
          state_d = S_CMUL;
        end
      end
      S_CMUL: begin
        if (md_done) begin
          tmp_d   = md_res;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        if (md_done) begin
          cell_d  = sat24(64'(min_s) + md_res);
          state_d = after_cell;
        end
      end
      S_PMUL: begin
        if (md_done) begin
          tmp_d   = md_res;
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        if (md_done) begin
          drop_d  = md_res[27:0];
          state_d = S_PCMUL;
        end
      end
      S_PCMUL: begin
        if (md_done) begin
          pack_d = sat24(md_res - 64'(drop_q));
          // A tick records the applied current and starts a fresh collection.
          if (op_q == OP_TICK) begin
            last_d    = pending_q;
            pending_d = '0;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          pack_out_d    = pack_q;
          cell_out_d    = cell_q;
          above_out_d   = (cell_q > 24'(min_s));
          applied_out_d = last_q;
          status_out_d  = status_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The unit is started once, in the first cycle of every multiply or divide step.
  assign issue_d = (state_d != state_q) && (state_d != S_IDLE) && (state_d != S_CELL) &&
                   (state_d != S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      charge_q    <= RST_CHARGE;
      pending_q   <= '0;
      last_q      <= '0;
      pack_q      <= RST_PACK;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
      charge_q    <= charge_d;
      pending_q   <= pending_d;
      last_q      <= last_d;
      pack_q      <= pack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    force_q       <= force_d;
    speed_q       <= speed_d;
    elapsed_q     <= elapsed_d;
    status_q      <= status_d;
    tot_q         <= tot_d;
    tmp_q         <= tmp_d;
    drop_q        <= drop_d;
    cell_q        <= cell_d;
    pack_out_q    <= pack_out_d;
    cell_out_q    <= cell_out_d;
    above_out_q   <= above_out_d;
    applied_out_q <= applied_out_d;
    status_out_q  <= status_out_d;
  end

  assign out_valid_o          = out_valid_q;
  assign pack_mv_o            = pack_out_q;
  assign cell_mv_o            = cell_out_q;
  assign above_minimum_o      = above_out_q;
  assign applied_current_ma_o = applied_out_q;
  assign status_o             = status_out_q;

endmodule

// File: rtl/core/bcc_checker.sv
// Port-level checks for the battery coulomb counter, bound to the top level.
// Depends on battery_coulomb_counter only through its port names.
module bcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] pack_mv_o,
  input logic signed [23:0] cell_mv_o,
  input logic               status_o,
  input logic               cfg_ready_o
);

  // A result that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pack_mv_o) &&
    $stable(cell_mv_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Once an item is taken the block is busy and closes the configuration port.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("block not busy after taking an item");

  // A result only appears at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in progress");

  // Finishing an item always leaves its result in the output register.
  a_release_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("item finished without a result");

endmodule

bind battery_coulomb_counter bcc_checker u_bcc_checker (.*);

// File: test/tb_battery_coulomb_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for battery_coulomb_counter: a directed table, then random rounds.
// Depends on bcc_pkg and the block itself; results are checked against a predictor held here.
module tb_battery_coulomb_counter;
  import bcc_pkg::*;

  localparam longint      MS_HOUR         = 3600000;
  localparam int unsigned QUIET_LIMIT     = 8000;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES     = 500;
  localparam int unsigned ROUNDS          = 8;
  localparam int unsigned ITEMS_PER_ROUND = 50;

  // Indexes that no register answers to.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [23:0] pack_mv;
    logic signed [23:0] cell_mv;
    logic               above_minimum;
    logic signed [20:0] applied_current_ma;
    logic               status;
  } reading_t;

  typedef struct {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [19:0]          reg_val;
    logic [1:0]           op;
    logic signed [20:0]   cur;
    logic signed [31:0]   force_mn;
    logic signed [31:0]   speed;
    logic [15:0]          elapsed;
    logic                 typed;
    reading_t             want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            op_i;
  logic signed [20:0]    current_ma_i;
  logic signed [31:0]    force_mn_i;
  logic signed [31:0]    speed_milli_i;
  logic [15:0]           elapsed_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [23:0]    pack_mv_o;
  logic signed [23:0]    cell_mv_o;
  logic                  above_minimum_o;
  logic signed [20:0]    applied_current_ma_o;
  logic                  status_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state.
  cfg_t   regs;
  longint held_charge;
  longint queued_ma;
  longint applied_ma;
  longint pack_level;

  reading_t    due_readings[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  logic        hold_off_req = 1'b0;

  battery_coulomb_counter uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .op_i                 (op_i),
    .current_ma_i         (current_ma_i),
    .force_mn_i           (force_mn_i),
    .speed_milli_i        (speed_milli_i),
    .elapsed_ms_i         (elapsed_ms_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .pack_mv_o            (pack_mv_o),
    .cell_mv_o            (cell_mv_o),
    .above_minimum_o      (above_minimum_o),
    .applied_current_ma_o (applied_current_ma_o),
    .status_o             (status_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clip(input longint v, input int unsigned bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Open-circuit cell voltage from the charge held now; no capacity leaves it at the minimum.
  function automatic longint cell_level();
    longint total;
    longint span;
    longint v;
    total = longint'(regs.capacity_mah) * MS_HOUR;
    span  = longint'(regs.max_cell_mv) - longint'(regs.min_cell_mv);
    v     = longint'(regs.min_cell_mv);
    if (total > 0) v += (held_charge * span) / total;
    return clip(v, 24);
  endfunction

  function automatic void refresh_pack(input longint load_ma);
    longint drop;
    drop = (longint'(regs.inner_resistance_mohm) * load_ma) / 1000;
    pack_level = clip(longint'(regs.cell_count) * cell_level() - drop, 24);
  endfunction

  function automatic void reload_charge();
    longint span;
    longint diff;
    span = longint'(regs.max_cell_mv) - longint'(regs.min_cell_mv);
    diff = longint'(regs.start_cell_mv) - longint'(regs.min_cell_mv);
    if (span == 0) held_charge = 0;
    else held_charge = clip((diff * longint'(regs.capacity_mah) * MS_HOUR) / span, 48);
  endfunction

  function automatic reading_t advance_pack(input logic [1:0] op, input logic signed [20:0] cur,
                                            input logic signed [31:0] f,
                                            input logic signed [31:0] s,
                                            input logic [15:0] el);
    reading_t r;
    longint   cell_now;
    logic     skipped;
    skipped = 1'b0;
    case (op)
      OP_CURRENT: queued_ma = clip(queued_ma + longint'(cur), 21);
      OP_MOTOR: begin
        if (pack_level <= 0) begin
          skipped = 1'b1;
        end else begin
          queued_ma = clip(queued_ma + clip((longint'(f) * longint'(s)) / pack_level, 24), 21);
        end
      end
      OP_TICK: begin
        held_charge = clip(held_charge - queued_ma * longint'(el), 48);
        refresh_pack(queued_ma);
        applied_ma = queued_ma;
        queued_ma  = 0;
      end
      default: begin
        // A restart takes its drop from the current still queued and keeps it queued.
        reload_charge();
        refresh_pack(queued_ma);
      end
    endcase
    cell_now             = cell_level();
    r.pack_mv            = pack_level[23:0];
    r.cell_mv            = cell_now[23:0];
    r.above_minimum      = (cell_now > longint'(regs.min_cell_mv));
    r.applied_current_ma = applied_ma[20:0];
    r.status             = skipped;
    return r;
  endfunction

  function automatic plan_row_t cmd_row(input logic [1:0] op, input logic signed [20:0] cur,
                                        input logic signed [31:0] f,
                                        input logic signed [31:0] s,
                                        input logic [15:0] el);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = REG_CELL_COUNT;
    row.reg_val  = '0;
    row.op       = op;
    row.cur      = cur;
    row.force_mn = f;
    row.speed    = s;
    row.elapsed  = el;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [1:0] op, input logic signed [20:0] cur,
                                          input logic signed [31:0] f,
                                          input logic signed [31:0] s,
                                          input logic [15:0] el,
                                          input logic signed [23:0] pack,
                                          input logic signed [23:0] cell_v, input logic above,
                                          input logic signed [20:0] applied, input logic flag);
    plan_row_t row;
    row       = cmd_row(op, cur, f, s, el);
    row.typed = 1'b1;
    row.want  = '{pack, cell_v, above, applied, flag};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
    plan_row_t row;
    row          = cmd_row(OP_CURRENT, '0, '0, '0, '0);
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    return row;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic offer_item(input logic [1:0] op, input logic signed [20:0] cur,
                            input logic signed [31:0] f, input logic signed [31:0] s,
                            input logic [15:0] el, input logic typed, input reading_t want);
    int unsigned gap;
    reading_t    predicted;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i          <= op;
    current_ma_i  <= cur;
    force_mn_i    <= f;
    speed_milli_i <= s;
    elapsed_ms_i  <= el;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_pack(op, cur, f, s, el);
    due_readings.push_back(typed ? want : predicted);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic        wide;
    logic [1:0]  op;
    int          c;
    int          f;
    int          s;
    logic [15:0] el;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    if (pick < 35) op = OP_CURRENT;
    else if (pick < 60) op = OP_MOTOR;
    else if (pick < 90) op = OP_TICK;
    else op = OP_RESTART;
    // Mostly plausible drive values, with a quarter spread over the whole field.
    c  = wide ? int'($urandom()) : int'($urandom_range(0, 60000)) - 10000;
    f  = wide ? int'($urandom()) : int'($urandom_range(0, 200000)) - 100000;
    s  = wide ? int'($urandom()) : int'($urandom_range(0, 10000)) - 5000;
    el = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 1000));
    offer_item(op, c[20:0], f, s, el, 1'b0, '0);
  endtask

  task automatic wait_settled();
    in_valid_i <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_CELL_COUNT: regs.cell_count = val[7:0];
      REG_MIN_CELL:   regs.min_cell_mv = val[15:0];
      REG_MAX_CELL:   regs.max_cell_mv = val[15:0];
      REG_START_CELL: regs.start_cell_mv = val[15:0];
      REG_CAPACITY:   regs.capacity_mah = val;
      REG_RESISTANCE: regs.inner_resistance_mohm = val[15:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned kind);
    logic [19:0] v [6];
    int unsigned lo_mv;
    case (kind)
      0: begin
        lo_mv = $urandom_range(2500, 3500);
        v[0]  = $urandom_range(10, 120);
        v[1]  = lo_mv;
        v[2]  = lo_mv + $urandom_range(300, 1200);
        v[3]  = $urandom_range(lo_mv - 200, lo_mv + 1400);
        v[4]  = $urandom_range(1, 5000);
        v[5]  = $urandom_range(0, 2000);
      end
      1: begin
        v[0] = 20'd1;
        v[1] = 20'd0;
        v[2] = 20'd1;
        v[3] = ($urandom_range(0, 1) != 0) ? 20'd65535 : 20'd0;
        v[4] = 20'd1;
        v[5] = 20'd0;
      end
      2: begin
        v[0] = 20'd255;
        v[1] = 20'd65534;
        v[2] = 20'd65535;
        v[3] = 20'd65535;
        v[4] = 20'd1000000;
        v[5] = 20'd65535;
      end
      default: begin
        v[0] = $urandom_range(1, 255);
        v[1] = $urandom_range(0, 65535);
        v[2] = $urandom_range(1, 65535);
        v[3] = $urandom_range(0, 65535);
        v[4] = $urandom_range(1, 1000000);
        v[5] = $urandom_range(0, 65535);
      end
    endcase
    write_reg(REG_CELL_COUNT, v[0]);
    write_reg(REG_MIN_CELL, v[1]);
    write_reg(REG_MAX_CELL, v[2]);
    write_reg(REG_START_CELL, v[3]);
    write_reg(REG_CAPACITY, v[4]);
    write_reg(REG_RESISTANCE, v[5]);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 20'($urandom()));
  endtask

  // Result side: a random stall around each result, and one long hold-off on request.
  initial begin : result_sink
    int unsigned pause;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      pause = rx_idle_on ? $urandom_range(0, 9) : 0;
      out_stall_i <= (pause != 0);
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pause != 0) begin
        repeat (pause - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
        while (!out_valid_o) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni !== 1'b1) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_readings.size() == 0) begin
          $display("%0t: result with nothing expected, pack_mv %0d", $time, pack_mv_o);
          errors++;
        end else begin
          want = due_readings.pop_front();
          check_field("pack_mv", want.pack_mv, pack_mv_o);
          check_field("cell_mv", want.cell_mv, cell_mv_o);
          check_field("above_minimum", want.above_minimum, above_minimum_o);
          check_field("applied_current_ma", want.applied_current_ma, applied_current_ma_o);
          check_field("status", want.status, status_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t script[$];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_CURRENT;
    current_ma_i  = '0;
    force_mn_i    = '0;
    speed_milli_i = '0;
    elapsed_ms_i  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_CELL_COUNT;
    cfg_data_i    = '0;

    regs = '{RST_CELL_COUNT, RST_MIN_CELL, RST_MAX_CELL, RST_START_CELL, RST_CAPACITY,
             RST_RESISTANCE};
    queued_ma  = 0;
    applied_ma = 0;
    reload_charge();
    refresh_pack(0);

    // After reset: a full pack at no load.
    script.push_back(known_row(OP_CURRENT, 0, 0, 0, 0, RST_PACK, 4200, 1'b1, 0, 1'b0));
    // Largest current, then one more to push the queued current into saturation.
    script.push_back(cmd_row(OP_CURRENT, 21'sh0FFFFF, 0, 0, 0));
    script.push_back(cmd_row(OP_CURRENT, 1, 0, 0, 0));
    // A zero-length tick applies the full drop and drives the pack negative.
    script.push_back(known_row(OP_TICK, 0, 0, 0, 0, -146572, 4200, 1'b1, 1048575, 1'b0));
    script.push_back(known_row(OP_MOTOR, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0,
                               -146572, 4200, 1'b1, 1048575, 1'b1));
    script.push_back(known_row(OP_RESTART, 0, 0, 0, 0, RST_PACK, 4200, 1'b1, 1048575, 1'b0));
    script.push_back(cmd_row(OP_CURRENT, 21'sh100000, 0, 0, 0));
    script.push_back(cmd_row(OP_CURRENT, -1, 0, 0, 0));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 16'hFFFF));
    script.push_back(cmd_row(OP_MOTOR, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0));
    script.push_back(cmd_row(OP_MOTOR, 0, 32'sh80000000, 32'sh80000000, 0));
    script.push_back(cmd_row(OP_MOTOR, 0, 32'sh80000000, 32'sh7FFFFFFF, 0));
    script.push_back(cmd_row(OP_MOTOR, 0, 0, 0, 0));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 16'hFFFF));
    script.push_back(cmd_row(OP_RESTART, 0, 0, 0, 0));
    // No capacity: the cell stays at its minimum.
    script.push_back(reg_row(REG_CAPACITY, 0));
    script.push_back(cmd_row(OP_CURRENT, 500, 0, 0, 0));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 1000));
    // Equal minimum and maximum: a restart empties the charge.
    script.push_back(reg_row(REG_MIN_CELL, 4000));
    script.push_back(reg_row(REG_MAX_CELL, 4000));
    script.push_back(reg_row(REG_CAPACITY, 1));
    script.push_back(cmd_row(OP_RESTART, 0, 0, 0, 0));
    // Maximum below minimum: the span turns negative.
    script.push_back(reg_row(REG_MIN_CELL, 4200));
    script.push_back(reg_row(REG_MAX_CELL, 3200));
    script.push_back(reg_row(REG_START_CELL, 3000));
    script.push_back(cmd_row(OP_RESTART, 0, 0, 0, 0));
    script.push_back(cmd_row(OP_CURRENT, 20000, 0, 0, 0));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 16'hFFFF));
    // A one millivolt span with a capacity of 1000000 overflows the charge on restart.
    script.push_back(reg_row(REG_MIN_CELL, 0));
    script.push_back(reg_row(REG_MAX_CELL, 1));
    script.push_back(reg_row(REG_START_CELL, 16'hFFFF));
    script.push_back(reg_row(REG_CAPACITY, 1000000));
    script.push_back(reg_row(REG_SPARE_A, 20'hFFFFF));
    script.push_back(reg_row(REG_SPARE_B, 5));
    script.push_back(cmd_row(OP_RESTART, 0, 0, 0, 0));
    script.push_back(cmd_row(OP_CURRENT, 21'sh100000, 0, 0, 0));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 16'hFFFF));
    script.push_back(reg_row(REG_CELL_COUNT, 255));
    script.push_back(reg_row(REG_RESISTANCE, 16'hFFFF));
    script.push_back(cmd_row(OP_TICK, 0, 0, 0, 1));
    script.push_back(cmd_row(OP_MOTOR, 0, 1000, 1000, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        wait_settled();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_item(script[i].op, script[i].cur, script[i].force_mn, script[i].speed,
                   script[i].elapsed, script[i].typed, script[i].want);
      end
    end
    wait_settled();

    for (int unsigned round = 0; round < ROUNDS; round++) begin
      apply_setting(round % 4);
      tx_idle_on = (round % 3 != 1);
      rx_idle_on = (round % 3 != 2);
      for (int unsigned n = 0; n < ITEMS_PER_ROUND; n++) begin
        // Hold the result side off long enough for the block to back up onto its input.
        if (round == 2 && n == 10) hold_off_req = 1'b1;
        send_random_item();
      end
      wait_settled();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_cfg.sv
rtl/core/bcc_muldiv.sv
rtl/core/battery_coulomb_counter.sv
rtl/core/bcc_checker.sv
test/tb_battery_coulomb_counter.sv
